/* sv/stack_vm_instruction_executor_top_assert.svh */
`ifndef STACK_VM_INSTRUCTION_EXECUTOR_TOP_ASSERT_SVH
`define STACK_VM_INSTRUCTION_EXECUTOR_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define SVM_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define SVM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/stkvm_pkg.sv */
package stkvm_pkg;

    // Memory and stack layout
    localparam int ADDR_BITS_DEF = 16;
    localparam int WORD_BITS     = 16;
    localparam int STACK_BASE    = 256;
    localparam int STACK_MAX     = 2047;
    localparam int STATIC_BASE   = 16;
    localparam int STATIC_MAX    = 255;
    localparam int POINTER_BASE  = 0;

    typedef enum logic [2:0] {
        ACT_PUSH  = 3'd0,
        ACT_POP   = 3'd1,
        ACT_LEA   = 3'd2,
        ACT_LOAD  = 3'd3,
        ACT_STORE = 3'd4,
        ACT_ADD   = 3'd5,
        ACT_SUB   = 3'd6,
        ACT_LABEL = 3'd7
    } action_t;

    // Segment code 3 is invalid
    typedef enum logic [1:0] {
        SEG_LOCAL  = 2'd0,
        SEG_STATIC = 2'd1,
        SEG_CONST  = 2'd2
    } segment_t;

    typedef enum logic [2:0] {
        STAT_OK     = 3'd0,
        STAT_OVER   = 3'd1,
        STAT_UNDER  = 3'd2,
        STAT_RANGE  = 3'd3,
        STAT_BADSEG = 3'd4,
        STAT_HALT   = 3'd5
    } status_t;

    // Source of the word written back at the end of an instruction
    typedef enum logic [2:0] {
        WS_IMM,
        WS_RD1,
        WS_RD2,
        WS_ADD,
        WS_SUB
    } wsrc_t;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_READ1,
        S_READ2
    } state_t;

    typedef struct packed {
        logic [2:0]           action;
        logic [1:0]           segment;
        logic [WORD_BITS-1:0] index;
    } instr_t;

    typedef struct packed {
        logic [2:0]           status;
        logic [WORD_BITS-1:0] top_value;
        logic [WORD_BITS-1:0] stack_pointer;
    } result_t;

    // Per-instruction access plan produced by the decoder
    typedef struct packed {
        status_t              status;
        logic                 rd1_en;
        logic [WORD_BITS-1:0] rd1_addr;
        logic [WORD_BITS-1:0] rd1_spval;
        logic                 rd2_en;
        logic                 rd2_indirect;
        logic [WORD_BITS-1:0] rd2_addr;
        logic [WORD_BITS-1:0] rd2_spval;
        logic                 wr_en;
        logic                 wr_addr_rd2;
        logic [WORD_BITS-1:0] wr_addr;
        wsrc_t                wsrc;
        logic [WORD_BITS-1:0] wr_imm;
        logic                 top_en;
        logic [WORD_BITS-1:0] sp_final;
        logic                 sp_last;
    } plan_t;

endpackage

/* sv/stkvm_decode.sv */
module stkvm_decode (
    input  stkvm_pkg::instr_t                    item,
    input  logic [stkvm_pkg::WORD_BITS-1:0]      sp,
    input  logic [stkvm_pkg::WORD_BITS-1:0]      lcl,
    input  logic                                 halted,
    output stkvm_pkg::plan_t                     plan
);
    import stkvm_pkg::*;

    // Stack checks made by a push seen at stack pointer s
    function automatic status_t push_check(input logic [31:0] s);
        status_t r;
        if (s > 32'(STACK_MAX))
            r = STAT_OVER;
        else if (s + 32'd1 < 32'(STACK_BASE))
            r = STAT_UNDER;
        else
            r = STAT_OK;
        return r;
    endfunction

    // Stack checks made by a pop seen at stack pointer s
    function automatic status_t pop_check(input logic [31:0] s);
        status_t r;
        if (s <= 32'(STACK_BASE))
            r = STAT_UNDER;
        else if (s - 32'd1 > 32'(STACK_MAX) + 32'd1)
            r = STAT_OVER;
        else
            r = STAT_OK;
        return r;
    endfunction

    logic [31:0]          sp32;
    logic [WORD_BITS-1:0] sp_m1;
    logic [WORD_BITS-1:0] sp_m2;
    logic [WORD_BITS-1:0] sp_p1;
    logic [WORD_BITS-1:0] seg_addr;
    logic                 seg_ok;
    logic                 seg_rng;
    status_t              st;

    // Segment address and its range check
    always_comb
    begin
        seg_addr = '0;
        seg_ok   = 1'b0;
        seg_rng  = 1'b0;
        case (item.segment)
            SEG_LOCAL:
            begin
                seg_addr = lcl + item.index;
                seg_ok   = 1'b1;
                seg_rng  = 32'(seg_addr) > 32'(STACK_MAX);
            end
            SEG_STATIC:
            begin
                seg_addr = WORD_BITS'(STATIC_BASE) + item.index;
                seg_ok   = 1'b1;
                seg_rng  = 32'(seg_addr) > 32'(STATIC_MAX);
            end
            default:
            begin
                seg_addr = '0;
                seg_ok   = 1'b0;
                seg_rng  = 1'b0;
            end
        endcase
    end

    // Checks and memory access plan per action
    always_comb
    begin
        sp32  = 32'(sp);
        sp_m1 = sp - WORD_BITS'(1);
        sp_m2 = sp - WORD_BITS'(2);
        sp_p1 = sp + WORD_BITS'(1);
        st    = STAT_OK;
        plan  = '0;
        plan.wsrc     = WS_IMM;
        plan.sp_final = sp;
        plan.sp_last  = 1'b1;

        case (action_t'(item.action))
            ACT_PUSH:
            begin
                if (item.segment == SEG_CONST)
                begin
                    st          = push_check(sp32);
                    plan.wr_imm = item.index;
                end
                else
                begin
                    if (!seg_ok)
                        st = STAT_BADSEG;
                    else if (seg_rng)
                        st = STAT_RANGE;
                    else
                        st = push_check(sp32);
                    plan.rd1_en    = 1'b1;
                    plan.rd1_addr  = seg_addr;
                    plan.rd1_spval = sp;
                    plan.wsrc      = WS_RD1;
                end
                plan.wr_en    = 1'b1;
                plan.wr_addr  = sp;
                plan.top_en   = 1'b1;
                plan.sp_final = sp_p1;
            end
            ACT_POP:
            begin
                st = pop_check(sp32);
                if (st == STAT_OK)
                begin
                    if (item.segment == SEG_CONST || !seg_ok)
                        st = STAT_BADSEG;
                    else if (seg_rng)
                        st = STAT_RANGE;
                end
                plan.rd1_en    = 1'b1;
                plan.rd1_addr  = sp_m1;
                plan.rd1_spval = sp_m1;
                plan.wr_en     = 1'b1;
                plan.wr_addr   = seg_addr;
                plan.wsrc      = WS_RD1;
                plan.sp_final  = sp_m1;
                plan.sp_last   = 1'b0;
            end
            ACT_LEA:
            begin
                if (!seg_ok)
                    st = STAT_BADSEG;
                else
                    st = push_check(sp32);
                plan.wr_en    = 1'b1;
                plan.wr_addr  = sp;
                plan.wr_imm   = seg_addr;
                plan.top_en   = 1'b1;
                plan.sp_final = sp_p1;
            end
            ACT_LOAD:
            begin
                st = pop_check(sp32);
                if (st == STAT_OK)
                    st = push_check(sp32 - 32'd1);
                plan.rd1_en       = 1'b1;
                plan.rd1_addr     = sp_m1;
                plan.rd1_spval    = sp_m1;
                plan.rd2_en       = 1'b1;
                plan.rd2_indirect = 1'b1;
                plan.rd2_spval    = sp_m1;
                plan.wr_en        = 1'b1;
                plan.wr_addr      = sp_m1;
                plan.wsrc         = WS_RD2;
                plan.top_en       = 1'b1;
                plan.sp_final     = sp;
            end
            ACT_STORE:
            begin
                st = pop_check(sp32);
                if (st == STAT_OK)
                    st = pop_check(sp32 - 32'd1);
                plan.rd1_en      = 1'b1;
                plan.rd1_addr    = sp_m1;
                plan.rd1_spval   = sp_m1;
                plan.rd2_en      = 1'b1;
                plan.rd2_addr    = sp_m2;
                plan.rd2_spval   = sp_m2;
                plan.wr_en       = 1'b1;
                plan.wr_addr_rd2 = 1'b1;
                plan.wsrc        = WS_RD1;
                plan.sp_final    = sp_m2;
                plan.sp_last     = 1'b0;
            end
            ACT_ADD, ACT_SUB:
            begin
                st = pop_check(sp32);
                if (st == STAT_OK)
                    st = pop_check(sp32 - 32'd1);
                if (st == STAT_OK)
                    st = push_check(sp32 - 32'd2);
                plan.rd1_en    = 1'b1;
                plan.rd1_addr  = sp_m1;
                plan.rd1_spval = sp_m1;
                plan.rd2_en    = 1'b1;
                plan.rd2_addr  = sp_m2;
                plan.rd2_spval = sp_m2;
                plan.wr_en     = 1'b1;
                plan.wr_addr   = sp_m2;
                plan.wsrc      = (action_t'(item.action) == ACT_ADD) ? WS_ADD : WS_SUB;
                plan.top_en    = 1'b1;
                plan.sp_final  = sp_m1;
            end
            default:
            begin
                st = STAT_OK;
            end
        endcase

        // A failed check or a halted machine touches nothing
        if (halted)
            st = STAT_HALT;
        plan.status = st;
        if (st != STAT_OK)
        begin
            plan.rd1_en   = 1'b0;
            plan.rd2_en   = 1'b0;
            plan.wr_en    = 1'b0;
            plan.top_en   = 1'b0;
            plan.sp_final = sp;
            plan.sp_last  = 1'b1;
        end
    end

endmodule

/* sv/stkvm_exec.sv */
module stkvm_exec #(
    parameter int ADDR_BITS = stkvm_pkg::ADDR_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    input  stkvm_pkg::instr_t  item,
    output logic               item_take,
    input  logic               res_ready,
    output logic               res_valid,
    output stkvm_pkg::result_t res,
    output logic               clear_busy
);
    import stkvm_pkg::*;

    localparam int DEPTH = 1 << ADDR_BITS;
    localparam logic [ADDR_BITS-1:0] SP_ADDR  = ADDR_BITS'(POINTER_BASE);
    localparam logic [ADDR_BITS-1:0] LCL_ADDR = ADDR_BITS'(POINTER_BASE + 1);

    // Word memory; the pointer words are served from sp_reg and lcl_reg
    logic [WORD_BITS-1:0] mem [0:DEPTH-1];
    logic [WORD_BITS-1:0] mem_q_reg;
    logic                 mem_we;
    logic [ADDR_BITS-1:0] mem_waddr;
    logic [WORD_BITS-1:0] mem_wdata;
    logic                 mem_re;
    logic [ADDR_BITS-1:0] mem_raddr;

    state_t               state_reg, state_next;
    logic [WORD_BITS-1:0] sp_reg, sp_next;
    logic [WORD_BITS-1:0] lcl_reg, lcl_next;
    logic                 halted_reg, halted_next;
    logic [ADDR_BITS-1:0] clr_cnt_reg, clr_cnt_next;
    plan_t                plan_reg;
    logic [WORD_BITS-1:0] rd1_reg;
    logic                 fwd_en_reg;
    logic [WORD_BITS-1:0] fwd_val_reg;

    plan_t                dec_plan;
    plan_t                cur_plan;
    logic                 fin;
    logic [WORD_BITS-1:0] rdata;
    logic [WORD_BITS-1:0] rd1_val;
    logic [WORD_BITS-1:0] wval;
    logic [WORD_BITS-1:0] waddr;
    logic                 hit_sp_w;
    logic                 hit_lcl_w;
    logic [WORD_BITS-1:0] rd_addr;
    logic [WORD_BITS-1:0] rd_spval;
    logic                 fwd_en;
    logic [WORD_BITS-1:0] fwd_val;

    stkvm_decode u_decode (
        .item   (item),
        .sp     (sp_reg),
        .lcl    (lcl_reg),
        .halted (halted_reg),
        .plan   (dec_plan)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (clr_cnt_reg == '1)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (item_valid && dec_plan.rd1_en)
                    state_next = S_READ1;
            end
            S_READ1:
            begin
                if (plan_reg.rd2_en)
                    state_next = S_READ2;
                else if (res_ready)
                    state_next = S_IDLE;
            end
            S_READ2:
            begin
                if (res_ready)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Read data with pointer-word forwarding
    assign rdata   = fwd_en_reg ? fwd_val_reg : mem_q_reg;
    assign rd1_val = (state_reg == S_READ2) ? rd1_reg : rdata;

    // Outputs of the sequencer
    always_comb
    begin
        cur_plan   = (state_reg == S_IDLE) ? dec_plan : plan_reg;
        clear_busy = (state_reg == S_CLEAR);
        item_take  = 1'b0;
        fin        = 1'b0;
        mem_re     = 1'b0;
        rd_addr    = '0;
        rd_spval   = '0;
        case (state_reg)
            S_IDLE:
            begin
                item_take = item_valid && (dec_plan.rd1_en || res_ready);
                fin       = item_valid && !dec_plan.rd1_en && res_ready;
                mem_re    = item_valid && dec_plan.rd1_en;
                rd_addr   = dec_plan.rd1_addr;
                rd_spval  = dec_plan.rd1_spval;
            end
            S_READ1:
            begin
                fin      = !plan_reg.rd2_en && res_ready;
                mem_re   = plan_reg.rd2_en;
                rd_addr  = plan_reg.rd2_indirect ? rdata : plan_reg.rd2_addr;
                rd_spval = plan_reg.rd2_spval;
            end
            S_READ2:
            begin
                fin = res_ready;
            end
            default:
            begin
                fin = 1'b0;
            end
        endcase
        mem_raddr = rd_addr[ADDR_BITS-1:0];
        fwd_en    = (mem_raddr == SP_ADDR) || (mem_raddr == LCL_ADDR);
        fwd_val   = (mem_raddr == SP_ADDR) ? rd_spval : lcl_reg;

        // Write-back value and address
        case (cur_plan.wsrc)
            WS_IMM:  wval = cur_plan.wr_imm;
            WS_RD1:  wval = rd1_val;
            WS_RD2:  wval = rdata;
            WS_ADD:  wval = rdata + rd1_val;
            WS_SUB:  wval = rdata - rd1_val;
            default: wval = cur_plan.wr_imm;
        endcase
        waddr     = cur_plan.wr_addr_rd2 ? rdata : cur_plan.wr_addr;
        hit_sp_w  = cur_plan.wr_en && (waddr[ADDR_BITS-1:0] == SP_ADDR);
        hit_lcl_w = cur_plan.wr_en && (waddr[ADDR_BITS-1:0] == LCL_ADDR);

        // Pointer updates; the later of the two writes to the SP word wins
        sp_next     = sp_reg;
        lcl_next    = lcl_reg;
        halted_next = halted_reg;
        if (fin)
        begin
            sp_next     = (!cur_plan.sp_last && hit_sp_w) ? wval : cur_plan.sp_final;
            lcl_next    = hit_lcl_w ? wval : lcl_reg;
            halted_next = halted_reg || (cur_plan.status != STAT_OK);
        end

        clr_cnt_next = clr_cnt_reg + ADDR_BITS'(1);
        mem_we       = clear_busy || (fin && cur_plan.wr_en);
        mem_waddr    = clear_busy ? clr_cnt_reg : waddr[ADDR_BITS-1:0];
        mem_wdata    = clear_busy ? '0 : wval;

        res_valid         = fin;
        res.status        = cur_plan.status;
        res.top_value     = cur_plan.top_en ? wval : '0;
        res.stack_pointer = sp_next;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            sp_reg      <= WORD_BITS'(STACK_BASE);
            lcl_reg     <= WORD_BITS'(STACK_BASE);
            halted_reg  <= 1'b0;
            clr_cnt_reg <= '0;
            fwd_en_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            sp_reg     <= sp_next;
            lcl_reg    <= lcl_next;
            halted_reg <= halted_next;
            if (clear_busy)
                clr_cnt_reg <= clr_cnt_next;
            if (mem_re)
                fwd_en_reg <= fwd_en;
        end
    end

    // Working registers of the instruction in flight
    always_ff @(posedge clk)
    begin
        if (item_take)
            plan_reg <= dec_plan;
        if (state_reg == S_READ1)
            rd1_reg <= rdata;
        if (mem_re)
            fwd_val_reg <= fwd_val;
    end

    // Memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            mem_q_reg <= mem[mem_raddr];
    end

endmodule

/* sv/stack_vm_instruction_executor_top.sv */
// Instruction classes: push constant, lea, label and any failing or halted step finish without
// a memory read; push local/static and pop make one read (S_READ1); load, store, add, sub make two
// (S_READ1, S_READ2). The word memory has a single read port with a registered read, and the
// executor takes a new instruction only once it is through with the last one.
// Reset loads both pointer words with STACK_BASE and clears the halt flag, then sweeps the
// word memory to zero with instr_ready held low.
module stack_vm_instruction_executor_top #(
    parameter int ADDR_BITS = stkvm_pkg::ADDR_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               instr_valid,
    output logic               instr_ready,
    input  stkvm_pkg::instr_t  instr,
    output logic               result_valid,
    input  logic               result_ready,
    output stkvm_pkg::result_t result
);
    import stkvm_pkg::*;

    logic    buf_valid_reg, buf_valid_next;
    instr_t  buf_item_reg;
    logic    out_valid_reg, out_valid_next;
    result_t out_item_reg;

    logic    item_take;
    logic    res_ready;
    logic    res_valid;
    result_t res;
    logic    clear_busy;

    stkvm_exec #(
        .ADDR_BITS (ADDR_BITS)
    ) u_exec (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (buf_valid_reg),
        .item       (buf_item_reg),
        .item_take  (item_take),
        .res_ready  (res_ready),
        .res_valid  (res_valid),
        .res        (res),
        .clear_busy (clear_busy)
    );

    // Input holding stage
    assign instr_ready = !clear_busy && (!buf_valid_reg || item_take);

    always_comb
    begin
        buf_valid_next = buf_valid_reg;
        if (instr_valid && instr_ready)
            buf_valid_next = 1'b1;
        else if (item_take)
            buf_valid_next = 1'b0;
    end

    // Result register
    assign res_ready = !out_valid_reg || result_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_valid)
            out_valid_next = 1'b1;
        else if (result_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            buf_valid_reg <= buf_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (instr_valid && instr_ready)
            buf_item_reg <= instr;
        if (res_valid)
            out_item_reg <= res;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_item_reg;

endmodule

/* sv/stkvm_checker.sv */
`include "stack_vm_instruction_executor_top_assert.svh"

module stkvm_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               instr_valid,
    input logic               instr_ready,
    input stkvm_pkg::instr_t  instr,
    input logic               result_valid,
    input logic               result_ready,
    input stkvm_pkg::result_t result
);
    import stkvm_pkg::*;

    logic                 halt_seen_reg, halt_seen_next;
    logic [WORD_BITS-1:0] halt_sp_reg, halt_sp_next;
    logic                 instr_seen;

    // Track the first failing result seen on the port
    always_comb
    begin
        instr_seen     = instr_valid && instr_ready && (instr.action <= ACT_LABEL);
        halt_seen_next = halt_seen_reg;
        halt_sp_next   = halt_sp_reg;
        if (result_valid && result_ready && !halt_seen_reg && result.status != STAT_OK)
        begin
            halt_seen_next = 1'b1;
            halt_sp_next   = result.stack_pointer;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            halt_seen_reg <= 1'b0;
            halt_sp_reg   <= '0;
        end
        else
        begin
            halt_seen_reg <= halt_seen_next || (halt_seen_reg && instr_seen);
            halt_sp_reg   <= halt_sp_next;
        end
    end

    // Once a step has failed, every later transaction reports the halted status
    `SVM_ASSERT_SAME(a_halt_sticky, clk, rst_n, result_valid && halt_seen_reg,
        result.status == STAT_HALT, "result after a failure is not halted")

    // A halted machine never moves its stack pointer
    `SVM_ASSERT_SAME(a_halt_sp_frozen, clk, rst_n, result_valid && halt_seen_reg,
        result.stack_pointer == halt_sp_reg, "stack pointer moved while halted")

    // A failing or halted step pushes nothing
    `SVM_ASSERT_SAME(a_fail_top_zero, clk, rst_n, result_valid && result.status != STAT_OK,
        result.top_value == '0, "nonzero top value on a failed step")

    // A stalled result holds
    `SVM_ASSERT_NEXT(a_result_hold, clk, rst_n, result_valid && !result_ready,
        result_valid && $stable(result), "stalled result changed")

endmodule

bind stack_vm_instruction_executor_top stkvm_checker u_stkvm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .instr_valid  (instr_valid),
    .instr_ready  (instr_ready),
    .instr        (instr),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);

/* test/tb_stack_vm_instruction_executor_top.sv */
`timescale 1ns / 1ps

module tb_stack_vm_instruction_executor_top;
    import stkvm_pkg::*;

    localparam int ADDR_BITS = ADDR_BITS_DEF;
    localparam int AMASK = (1 << ADDR_BITS) - 1;
    localparam logic [15:0] SP_ADDR = 16'(POINTER_BASE & AMASK);
    localparam logic [15:0] LCL_ADDR = 16'((POINTER_BASE + 1) & AMASK);
    localparam logic [1:0] SEG_INVALID = 2'd3;
    localparam int RANDOM_ITEMS = 600;
    localparam int DIRECTED_ITEMS = 25;
    localparam int LIMIT_CYCLES = 600000;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_REPORTS = 20;

    // Shadow of the executor: word memory, halt flag, queue of results still owed
    class vm_scoreboard;
        bit [15:0] mem [0:AMASK];
        bit halted;
        bit [15:0] undo_addr [4];
        bit [15:0] undo_old [4];
        int undo_n;
        result_t pending_results [$];
        int n_noted;
        int n_checked;
        int n_failed;
        int n_ok;
        int n_halted;

        function new();
            foreach (mem[i]) mem[i] = '0;
            mem[SP_ADDR] = 16'(STACK_BASE);
            mem[LCL_ADDR] = 16'(STACK_BASE);
            halted = 1'b0;
            undo_n = 0;
        endfunction

        function logic [15:0] word_at(logic [15:0] a);
            return mem[a & AMASK];
        endfunction

        // Every write is logged so a failed or trial step can be backed out
        function void write_word(logic [15:0] a, logic [15:0] v);
            if (undo_n < 4) begin
                undo_addr[undo_n] = a & AMASK;
                undo_old[undo_n] = mem[a & AMASK];
                undo_n++;
            end
            mem[a & AMASK] = v;
        endfunction

        function void rollback();
            while (undo_n > 0) begin
                undo_n--;
                mem[undo_addr[undo_n]] = undo_old[undo_n];
            end
        endfunction

        function status_t push_word(logic [15:0] v);
            int sp;
            sp = word_at(SP_ADDR);
            if (sp > STACK_MAX) return STAT_OVER;
            if (sp + 1 < STACK_BASE) return STAT_UNDER;
            write_word(16'(sp), v);
            write_word(SP_ADDR, 16'(sp + 1));
            return STAT_OK;
        endfunction

        function status_t pop_word(output logic [15:0] v);
            int sp;
            v = '0;
            sp = word_at(SP_ADDR);
            if (sp <= STACK_BASE) return STAT_UNDER;
            if (sp - 1 > STACK_MAX + 1) return STAT_OVER;
            sp--;
            write_word(SP_ADDR, 16'(sp));
            v = word_at(16'(sp));
            return STAT_OK;
        endfunction

        // Local and static slots; sums wrap at 16 bits
        function status_t slot_addr(logic [1:0] seg, logic [15:0] idx, bit check,
                                    output logic [15:0] addr);
            addr = '0;
            if (seg == SEG_LOCAL) begin
                addr = word_at(LCL_ADDR) + idx;
                if (check && addr > STACK_MAX) return STAT_RANGE;
                return STAT_OK;
            end
            if (seg == SEG_STATIC) begin
                addr = 16'(STATIC_BASE) + idx;
                if (check && addr > STATIC_MAX) return STAT_RANGE;
                return STAT_OK;
            end
            return STAT_BADSEG;
        endfunction

        function status_t exec_instr(instr_t it, output logic [15:0] top);
            logic [15:0] a;
            logic [15:0] b;
            logic [15:0] addr;
            status_t st;
            top = '0;
            a = '0;
            b = '0;
            addr = '0;
            case (it.action)
                ACT_PUSH: begin
                    if (it.segment == SEG_CONST) begin
                        a = it.index;
                    end
                    else begin
                        st = slot_addr(it.segment, it.index, 1'b1, addr);
                        if (st != STAT_OK) return st;
                        a = word_at(addr);
                    end
                    top = a;
                    return push_word(a);
                end
                ACT_POP: begin
                    st = pop_word(a);
                    if (st != STAT_OK) return st;
                    if (it.segment == SEG_CONST) return STAT_BADSEG;
                    st = slot_addr(it.segment, it.index, 1'b1, addr);
                    if (st != STAT_OK) return st;
                    write_word(addr, a);
                    return STAT_OK;
                end
                ACT_LEA: begin
                    st = slot_addr(it.segment, it.index, 1'b0, addr);
                    if (st != STAT_OK) return st;
                    top = addr;
                    return push_word(addr);
                end
                ACT_LOAD: begin
                    st = pop_word(a);
                    if (st != STAT_OK) return st;
                    b = word_at(a);
                    top = b;
                    return push_word(b);
                end
                ACT_STORE: begin
                    st = pop_word(b);
                    if (st != STAT_OK) return st;
                    st = pop_word(a);
                    if (st != STAT_OK) return st;
                    write_word(a, b);
                    return STAT_OK;
                end
                ACT_ADD, ACT_SUB: begin
                    st = pop_word(b);
                    if (st != STAT_OK) return st;
                    st = pop_word(a);
                    if (st != STAT_OK) return st;
                    a = (it.action == ACT_ADD) ? a + b : a - b;
                    top = a;
                    return push_word(a);
                end
                default: return STAT_OK;
            endcase
        endfunction

        // One step; without commit the state is left as it was
        function void step(instr_t it, bit commit, output result_t res);
            logic [15:0] top;
            status_t st;
            if (halted) begin
                res.status = STAT_HALT;
                res.top_value = '0;
                res.stack_pointer = word_at(SP_ADDR);
                return;
            end
            undo_n = 0;
            st = exec_instr(it, top);
            if (st != STAT_OK) begin
                rollback();
                top = '0;
            end
            res.status = st;
            res.top_value = top;
            res.stack_pointer = word_at(SP_ADDR);
            if (!commit) rollback();
            else if (st != STAT_OK) halted = 1'b1;
            undo_n = 0;
        endfunction

        function result_t trial(instr_t it);
            result_t res;
            step(it, 1'b0, res);
            return res;
        endfunction

        function void note_instr(instr_t it);
            result_t res;
            step(it, 1'b1, res);
            pending_results.push_back(res);
            n_noted++;
            if (res.status == STAT_OK) n_ok++;
            if (res.status == STAT_HALT) n_halted++;
        endfunction

        function void fail(string what, logic [15:0] exp_v, logic [15:0] got_v);
            n_failed++;
            if (n_failed <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, exp_v, got_v);
        endfunction

        function void check_result(result_t got);
            result_t exp;
            if (pending_results.size() == 0) begin
                n_failed++;
                if (n_failed <= MAX_REPORTS)
                    $display("%0t: unexpected result, expected none, actual status %0d top %0d sp %0d",
                             $time, got.status, got.top_value, got.stack_pointer);
                return;
            end
            exp = pending_results.pop_front();
            n_checked++;
            if (got.status !== exp.status) fail("status", 16'(exp.status), 16'(got.status));
            if (got.top_value !== exp.top_value) fail("top_value", exp.top_value, got.top_value);
            if (got.stack_pointer !== exp.stack_pointer)
                fail("stack_pointer", exp.stack_pointer, got.stack_pointer);
        endfunction

        function void finish();
            if (pending_results.size() != 0) begin
                n_failed++;
                $display("%0t: results missing, expected %0d more, actual 0",
                         $time, pending_results.size());
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic instr_valid = 1'b0;
    logic instr_ready;
    instr_t instr = '0;
    logic result_valid;
    logic result_ready = 1'b0;
    result_t result;

    vm_scoreboard sb = new();
    int burst_left = 0;
    int work_items = 0;
    int cycles = 0;
    int ready_mode = 0;
    int ready_hold = 0;
    int fault_kind = 0;
    string fault_name [12] = '{"push overflow", "push underflow", "pop underflow",
        "pop overflow", "push local range", "pop local range", "push static range",
        "pop static range", "pop constant", "lea constant", "invalid segment",
        "binary op underflow"};

    stack_vm_instruction_executor_top #(
        .ADDR_BITS(ADDR_BITS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .instr_valid(instr_valid),
        .instr_ready(instr_ready),
        .instr(instr),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result(result)
    );

    always #10 clk = ~clk;

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycles);
            $display("stack_vm_instruction_executor_top regression: fail");
            $finish;
        end
    end

    // Result side: check each transaction, stall in modes of random length
    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready) sb.check_result(result);
        if (ready_hold == 0) begin
            ready_mode = $urandom_range(0, 2);
            ready_hold = $urandom_range(20, 200);
        end
        ready_hold--;
        case (ready_mode)
            0: result_ready <= 1'b1;
            1: result_ready <= 1'($urandom_range(0, 1));
            default: result_ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    function automatic instr_t mk(action_t a, logic [1:0] s, logic [15:0] i);
        instr_t it;
        it.action = a;
        it.segment = s;
        it.index = i;
        return it;
    endfunction

    // A step is safe when it passes and leaves SP where the stack stays usable
    function automatic bit safe(instr_t it);
        result_t r;
        r = sb.trial(it);
        return r.status == STAT_OK && r.stack_pointer >= STACK_BASE &&
               r.stack_pointer <= STACK_MAX + 1;
    endfunction

    // Instruction transaction in bursts with random gaps; guarded items that would
    // fault are replaced by a label
    task automatic send(input instr_t it, input bit guarded);
        int gap;
        if (guarded && !safe(it))
            it = mk(ACT_LABEL, 2'($urandom_range(0, 3)), 16'($urandom()));
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                instr_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        instr <= it;
        instr_valid <= 1'b1;
        @(posedge clk);
        while (!instr_ready) @(posedge clk);
        sb.note_instr(it);
        if (it.action != ACT_LABEL) work_items++;
    endtask

    // Write v to any address through push, push, store
    task automatic poke(input logic [15:0] addr, input logic [15:0] v, input bit guarded);
        send(mk(ACT_PUSH, SEG_CONST, addr), guarded);
        send(mk(ACT_PUSH, SEG_CONST, v), guarded);
        send(mk(ACT_STORE, SEG_LOCAL, 16'($urandom())), guarded);
    endtask

    function automatic instr_t draw_single();
        int w;
        logic [1:0] s;
        logic [15:0] i;
        logic [15:0] lcl;
        action_t a;
        lcl = sb.word_at(LCL_ADDR);
        s = 2'($urandom_range(0, 3));
        i = 16'($urandom());
        // raw noise
        if ($urandom_range(0, 4) == 0) return mk(action_t'($urandom_range(0, 7)), s, i);
        w = $urandom_range(0, 99);
        if (w < 25) a = ACT_PUSH;
        else if (w < 40) a = ACT_POP;
        else if (w < 48) a = ACT_LEA;
        else if (w < 56) a = ACT_LOAD;
        else if (w < 65) a = ACT_STORE;
        else if (w < 78) a = ACT_ADD;
        else if (w < 92) a = ACT_SUB;
        else a = ACT_LABEL;
        case (a)
            ACT_PUSH, ACT_POP: begin
                s = (a == ACT_PUSH) ? 2'($urandom_range(0, 2)) : 2'($urandom_range(0, 1));
                if (s == SEG_LOCAL)
                    i = 16'($urandom_range(0, STACK_MAX)) - lcl;
                else if (s == SEG_STATIC)
                    i = 16'($urandom_range(0, STATIC_MAX)) - 16'(STATIC_BASE);
                else if ($urandom_range(0, 3) == 0)
                    i = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
            end
            ACT_LEA: s = 2'($urandom_range(0, 1));
            default: ;
        endcase
        return mk(a, s, i);
    endfunction

    task automatic random_step();
        int r;
        int sp;
        logic [15:0] addr;
        instr_t it;
        r = $urandom_range(0, 99);
        sp = sb.word_at(SP_ADDR);
        if (r < 5 && sp <= STACK_MAX - 1) begin
            // move the stack pointer, mostly near the base
            if ($urandom_range(0, 4) != 0)
                poke(SP_ADDR, 16'(STACK_BASE + $urandom_range(0, 40)), 1'b1);
            else
                poke(SP_ADDR, 16'($urandom_range(STACK_BASE, STACK_MAX + 1)), 1'b1);
        end
        else if (r < 8 && sp <= STACK_MAX - 1) begin
            // move the local base
            if ($urandom_range(0, 1) != 0)
                poke(LCL_ADDR, 16'($urandom_range(STACK_BASE, STACK_MAX)), 1'b1);
            else
                poke(LCL_ADDR, 16'($urandom()), 1'b1);
        end
        else if (r < 13 && sp <= STACK_MAX - 1) begin
            // store to an arbitrary word, then load it back
            addr = 16'($urandom_range(2, 65535));
            poke(addr, 16'($urandom()), 1'b1);
            send(mk(ACT_PUSH, SEG_CONST, addr), 1'b1);
            send(mk(ACT_LOAD, 2'($urandom_range(0, 3)), 16'($urandom())), 1'b1);
        end
        else begin
            it = draw_single();
            for (int k = 0; k < 10 && !safe(it); k++) it = draw_single();
            send(it, 1'b1);
        end
    endtask

    // One fault per run, picked at random; everything after it sees the halt
    task automatic inject_fault();
        logic [15:0] lcl;
        action_t a;
        while (sb.word_at(SP_ADDR) > STACK_MAX - 1)
            send(mk(ACT_POP, SEG_STATIC, 16'h0000), 1'b1);
        lcl = sb.word_at(LCL_ADDR);
        fault_kind = $urandom_range(0, 11);
        case (fault_kind)
            0: begin
                poke(SP_ADDR, 16'($urandom_range(STACK_MAX + 1, 65535)), 1'b0);
                send(mk(ACT_PUSH, SEG_CONST, 16'($urandom())), 1'b0);
            end
            1: begin
                poke(SP_ADDR, 16'($urandom_range(0, STACK_BASE - 2)), 1'b0);
                send(mk(ACT_PUSH, SEG_CONST, 16'($urandom())), 1'b0);
            end
            2: begin
                poke(SP_ADDR, 16'($urandom_range(0, STACK_BASE)), 1'b0);
                send(mk(ACT_POP, SEG_STATIC, 16'h0000), 1'b0);
            end
            3: begin
                poke(SP_ADDR, 16'($urandom_range(STACK_MAX + 3, 65535)), 1'b0);
                send(mk(ACT_POP, SEG_STATIC, 16'h0000), 1'b0);
            end
            4: send(mk(ACT_PUSH, SEG_LOCAL,
                       16'($urandom_range(STACK_MAX + 1, 65535)) - lcl), 1'b0);
            5: begin
                send(mk(ACT_PUSH, SEG_CONST, 16'($urandom())), 1'b0);
                send(mk(ACT_POP, SEG_LOCAL,
                        16'($urandom_range(STACK_MAX + 1, 65535)) - lcl), 1'b0);
            end
            6: send(mk(ACT_PUSH, SEG_STATIC,
                       16'($urandom_range(STATIC_MAX + 1, 65535)) - 16'(STATIC_BASE)), 1'b0);
            7: begin
                send(mk(ACT_PUSH, SEG_CONST, 16'($urandom())), 1'b0);
                send(mk(ACT_POP, SEG_STATIC,
                        16'($urandom_range(STATIC_MAX + 1, 65535)) - 16'(STATIC_BASE)), 1'b0);
            end
            8: begin
                send(mk(ACT_PUSH, SEG_CONST, 16'($urandom())), 1'b0);
                send(mk(ACT_POP, SEG_CONST, 16'($urandom())), 1'b0);
            end
            9: send(mk(ACT_LEA, SEG_CONST, 16'($urandom())), 1'b0);
            10: begin
                send(mk(ACT_PUSH, SEG_CONST, 16'($urandom())), 1'b0);
                a = action_t'($urandom_range(ACT_PUSH, ACT_LEA));
                send(mk(a, SEG_INVALID, 16'($urandom())), 1'b0);
            end
            default: begin
                poke(SP_ADDR, 16'(STACK_BASE + 1), 1'b0);
                a = action_t'($urandom_range(ACT_STORE, ACT_SUB));
                send(mk(a, 2'($urandom_range(0, 3)), 16'($urandom())), 1'b0);
            end
        endcase
        // halted from here on
        repeat (6)
            send(mk(action_t'($urandom_range(0, 7)), 2'($urandom_range(0, 3)),
                    16'($urandom())), 1'b0);
    endtask

    // Directed corners: wraps, range limits, stack pointer edges, every operation
    task automatic run_directed();
        send(mk(ACT_LABEL, SEG_INVALID, 16'hFFFF), 1'b0);
        send(mk(ACT_PUSH, SEG_CONST, 16'hFFFF), 1'b0);
        send(mk(ACT_PUSH, SEG_CONST, 16'h0001), 1'b0);
        send(mk(ACT_ADD, SEG_LOCAL, 16'h0000), 1'b0);
        send(mk(ACT_PUSH, SEG_CONST, 16'h0000), 1'b0);
        send(mk(ACT_PUSH, SEG_CONST, 16'h0001), 1'b0);
        send(mk(ACT_SUB, SEG_INVALID, 16'hFFFF), 1'b0);
        send(mk(ACT_POP, SEG_STATIC, 16'(STATIC_MAX - STATIC_BASE)), 1'b0);
        send(mk(ACT_PUSH, SEG_STATIC, 16'(STATIC_MAX - STATIC_BASE)), 1'b0);
        send(mk(ACT_POP, SEG_LOCAL, 16'(STACK_MAX - STACK_BASE)), 1'b0);
        send(mk(ACT_PUSH, SEG_LOCAL, 16'(STACK_MAX - STACK_BASE)), 1'b0);
        send(mk(ACT_LEA, SEG_LOCAL, 16'hFFFF), 1'b0);
        send(mk(ACT_LEA, SEG_STATIC, 16'hFFFF), 1'b0);
        send(mk(ACT_LOAD, SEG_CONST, 16'h0000), 1'b0);
        send(mk(ACT_POP, SEG_STATIC, 16'h0000), 1'b0);
        // lowest SP that still pushes
        poke(SP_ADDR, 16'(STACK_BASE - 1), 1'b0);
        send(mk(ACT_PUSH, SEG_CONST, 16'h5555), 1'b0);
        // highest SP that still pops, then the last free slot
        poke(SP_ADDR, 16'(STACK_MAX + 2), 1'b0);
        send(mk(ACT_POP, SEG_STATIC, 16'h0002), 1'b0);
        send(mk(ACT_POP, SEG_STATIC, 16'h0003), 1'b0);
        send(mk(ACT_PUSH, SEG_CONST, 16'hAAAA), 1'b0);
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        run_directed();
        while (work_items < DIRECTED_ITEMS + RANDOM_ITEMS) random_step();
        inject_fault();
        instr_valid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        sb.finish();
        $display("%0d instructions sent (%0d doing work), %0d results checked, %0d ok, %0d halted",
                 sb.n_noted, work_items, sb.n_checked, sb.n_ok, sb.n_halted);
        $display("closing fault: %s, mismatches: %0d", fault_name[fault_kind], sb.n_failed);
        if (sb.n_failed == 0)
            $display("stack_vm_instruction_executor_top regression: pass");
        else
            $display("stack_vm_instruction_executor_top regression: fail");
        $finish;
    end

endmodule

/* stack_vm_instruction_executor_top.f */
+incdir+sv
sv/stkvm_pkg.sv
sv/stkvm_decode.sv
sv/stkvm_exec.sv
sv/stack_vm_instruction_executor_top.sv
sv/stkvm_checker.sv
test/tb_stack_vm_instruction_executor_top.sv
